// ===== rtl/rcf_pkg.sv =====
// Shared types and constants for the RGB crossfade block.
package rcf_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned CHANS       = 3;
    localparam int unsigned RGB_W       = CHAN_W * CHANS;
    localparam int unsigned NUM_LANES   = 2 * CHANS;
    localparam int unsigned DUR_W       = 16;

    // request opcodes
    localparam logic CMD_TARGET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Progress runs 0..999 in units of 1/1000 of the fade.
    localparam int unsigned PCT_SCALE   = 1000;
    localparam int unsigned PROG_W      = 10;

    // floor(x / 1000) for x < 2^18: estimate by x * 1048 >> 20, then one
    // add-back step (the estimate is low by at most one).
    localparam int unsigned RECIP_MUL   = 1048;
    localparam int unsigned RECIP_SHIFT = 20;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [RGB_W-1:0]  t_rgb;
    typedef logic [PROG_W-1:0] t_prog;
    typedef logic [DUR_W-1:0]  t_dur;

endpackage

// ===== rtl/rgb_color_crossfade.sv =====
// Top level of the RGB crossfade block: command sequencer, fade state and lane merge.
//
// Holds a primary and a secondary target color and the colors now shown, and
// answers every request with exactly one result. A target request (cmd 0)
// stores new targets and either snaps the shown colors to them (snap_now set
// or duration zero) or starts a fade from the shown colors (optionally from
// black) stamped with now_ms, unless those already equal the targets. A tick
// request (cmd 1) during a fade computes progress = elapsed * 1000 / duration
// on a 10-step serial divider, then six parallel lanes (R, G, B of both colors)
// blend each channel in a 3-stage pipeline and the results are merged back into
// packed colors. Once elapsed reaches the duration the fade snaps to target and
// changed is raised. A tick inside a running fade passes from accept through the
// serial divider and then the lane pipeline before its result is registered;
// target requests, idle ticks and the tick that ends a fade go from evaluation
// straight to the result register. One request is in flight at a time; the
// result sits in an output register so a new request may be accepted while it
// waits to be taken. Elapsed time wraps modulo 2^TIME_BITS. The duration
// register may be written only while no request is in flight.
module rgb_color_crossfade
    import rcf_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [31:0] i_now_ms,
    input  t_rgb        i_new_primary,
    input  t_rgb        i_new_secondary,
    input  logic        i_from_black,
    input  logic        i_snap_now,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rgb        o_shown_primary,
    output t_rgb        o_shown_secondary,
    output logic        o_changed,
    output logic        o_fading,
    // duration register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_dur        i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam t_rgb WHITE = '1;
    localparam t_rgb BLACK = '0;

    logic [2:0]           r_state, n_state;

    // latched request
    logic                 r_cmd;
    logic [TIME_BITS-1:0] r_now;
    t_rgb                 r_np, r_ns;
    logic                 r_blk, r_snap;
    t_rgb                 r_prev_p, r_prev_s;
    logic                 r_done;

    // fade state
    t_dur                 r_dur;
    t_rgb                 r_goal_p, r_goal_s;
    t_rgb                 r_cur_p, r_cur_s;
    t_rgb                 r_org_p, r_org_s;
    logic                 r_fade_on;
    logic [TIME_BITS-1:0] r_start_time;

    // result register
    logic                 r_out_valid;
    t_rgb                 r_out_p, r_out_s;
    logic                 r_out_chg, r_out_fade;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;
    logic                 accept;
    logic                 out_free;
    logic                 div_start;
    logic                 div_done;
    t_prog                progress;
    t_rgb                 cb_p, cb_s;
    logic                 snap_req;

    t_chan                lane_from [NUM_LANES];
    t_chan                lane_to   [NUM_LANES];
    t_chan                lane_out  [NUM_LANES];
    logic [NUM_LANES-1:0] lane_vld;
    t_rgb                 blend_p, blend_s;

    // time stamp narrowed or widened to TIME_BITS
    generate
        if (TIME_BITS > 32) begin : g_time_wide
            assign now_t = {{(TIME_BITS-32){1'b0}}, i_now_ms};
        end else if (TIME_BITS == 32) begin : g_time_eq
            assign now_t = i_now_ms;
        end else begin : g_time_narrow
            assign now_t = i_now_ms[TIME_BITS-1:0];
        end
    endgenerate

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign elapsed  = r_now - r_start_time;
    assign expired  = (elapsed >= TIME_BITS'(r_dur));
    assign snap_req = r_snap || (r_dur == '0);
    assign cb_p     = r_blk ? BLACK : r_cur_p;
    assign cb_s     = r_blk ? BLACK : r_cur_s;

    // divider runs only on a tick inside a fade that has not yet run out
    assign div_start = (r_state == S_EVAL) && (r_cmd == CMD_TICK) && r_fade_on && !expired;

    rcf_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_elapsed (elapsed[DUR_W-1:0]),
        .i_divisor (r_dur),
        .o_done    (div_done),
        .o_quot    (progress)
    );

    // lanes 0..2 are R,G,B of the primary, 3..5 of the secondary
    generate
        for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
            localparam int unsigned LO = CHAN_W * (CHANS - 1 - (k % CHANS));
            if (k < CHANS) begin : g_pri
                assign lane_from[k] = r_org_p[LO +: CHAN_W];
                assign lane_to[k]   = r_goal_p[LO +: CHAN_W];
                assign blend_p[LO +: CHAN_W] = lane_out[k];
            end else begin : g_sec
                assign lane_from[k] = r_org_s[LO +: CHAN_W];
                assign lane_to[k]   = r_goal_s[LO +: CHAN_W];
                assign blend_s[LO +: CHAN_W] = lane_out[k];
            end
            rcf_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_start    (div_done),
                .i_from     (lane_from[k]),
                .i_to       (lane_to[k]),
                .i_progress (progress),
                .o_valid    (lane_vld[k]),
                .o_chan     (lane_out[k])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EVAL;
            S_EVAL:  n_state = div_start ? S_DIV : S_DONE;
            S_DIV:   if (div_done) n_state = S_BLEND;
            S_BLEND: if (lane_vld[0]) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and fade state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dur        <= t_dur'(PCT_SCALE);
            r_goal_p     <= WHITE;
            r_goal_s     <= BLACK;
            r_cur_p      <= WHITE;
            r_cur_s      <= BLACK;
            r_org_p      <= WHITE;
            r_org_s      <= BLACK;
            r_fade_on    <= 1'b0;
            r_start_time <= '0;
            r_done       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                r_dur <= i_cfg_data;
            end

            if (r_state == S_EVAL) begin
                r_done <= 1'b0;
                if (r_cmd == CMD_TARGET) begin
                    r_goal_p <= r_np;
                    r_goal_s <= r_ns;
                    if (snap_req) begin
                        r_cur_p      <= r_np;
                        r_cur_s      <= r_ns;
                        r_org_p      <= r_np;
                        r_org_s      <= r_ns;
                        r_fade_on    <= 1'b0;
                        r_start_time <= '0;
                    end else begin
                        r_cur_p <= cb_p;
                        r_cur_s <= cb_s;
                        if (cb_p == r_np && cb_s == r_ns) begin
                            r_fade_on    <= 1'b0;
                            r_start_time <= '0;
                        end else begin
                            r_org_p      <= cb_p;
                            r_org_s      <= cb_s;
                            r_fade_on    <= 1'b1;
                            r_start_time <= r_now;
                        end
                    end
                end else if (r_fade_on && expired) begin
                    // fade complete: snap to target
                    r_cur_p      <= r_goal_p;
                    r_cur_s      <= r_goal_s;
                    r_org_p      <= r_goal_p;
                    r_org_s      <= r_goal_s;
                    r_fade_on    <= 1'b0;
                    r_start_time <= '0;
                    r_done       <= 1'b1;
                end
            end

            // merge the lane results back into packed colors
            if (r_state == S_BLEND && lane_vld[0]) begin
                r_cur_p <= blend_p;
                r_cur_s <= blend_s;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_now    <= now_t;
            r_np     <= i_new_primary;
            r_ns     <= i_new_secondary;
            r_blk    <= i_from_black;
            r_snap   <= i_snap_now;
            r_prev_p <= r_cur_p;
            r_prev_s <= r_cur_s;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_p    <= r_cur_p;
            r_out_s    <= r_cur_s;
            r_out_chg  <= r_done || (r_cur_p != r_prev_p) || (r_cur_s != r_prev_s);
            r_out_fade <= r_fade_on;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_shown_primary   = r_out_p;
    assign o_shown_secondary = r_out_s;
    assign o_changed         = r_out_chg;
    assign o_fading          = r_out_fade;

    // divider finishes only while the sequencer waits for it
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    // lane results arrive only while the sequencer waits for them
    a_lane_in_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_vld[0] |-> (r_state == S_BLEND))
        else $error("lane result outside blend state");

    // all lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_vld == '0) || (lane_vld == '1))
        else $error("lanes out of step");

    // an accepted request is evaluated on the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EVAL))
        else $error("accepted request not evaluated");

    // a result carrying the fade flag never reports a completion with the fade still on
    a_fade_vs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !(r_done && r_fade_on))
        else $error("fade still on after completion");

endmodule

// ===== rtl/rcf_div.sv =====
// Serial divider: progress = elapsed * 1000 / duration, one quotient bit per cycle.
module rcf_div
    import rcf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_dur  i_elapsed,
    input  t_dur  i_divisor,
    output logic  o_done,
    output t_prog o_quot
);

    localparam int unsigned PROD_W = DUR_W + PROG_W;
    localparam int unsigned CNT_W  = $clog2(PROG_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    t_dur              r_rem;
    t_prog             r_low;
    t_prog             r_quot;
    logic              r_done;

    logic [PROD_W-1:0] prod;
    logic [DUR_W:0]    trial;
    logic              ge;
    t_dur              n_rem;

    // quotient < 2^PROG_W, so the upper dividend bits start below the divisor
    assign prod  = PROD_W'(i_elapsed) * PROD_W'(PCT_SCALE);
    assign trial = {r_rem, r_low[PROG_W-1]};
    assign ge    = (trial >= {1'b0, i_divisor});
    assign n_rem = ge ? DUR_W'(trial - {1'b0, i_divisor}) : trial[DUR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= prod[PROD_W-1:PROG_W];
            r_low  <= prod[PROG_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[PROG_W-2:0], 1'b0};
            r_quot <= {r_quot[PROG_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/rcf_lane.sv =====
// One color channel blend lane: from + trunc((to - from) * progress / 1000).
module rcf_lane
    import rcf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_chan i_from,
    input  t_chan i_to,
    input  t_prog i_progress,
    output logic  o_valid,
    output t_chan o_chan
);

    localparam int unsigned MAG_W = CHAN_W + PROG_W;
    localparam int unsigned EST_W = MAG_W + 11;

    logic [2:0]       r_v;
    t_chan            r_from1, r_from2;
    logic             r_neg1, r_neg2;
    logic [MAG_W-1:0] r_prod1, r_prod2;
    t_chan            r_est2;
    t_chan            r_chan;

    logic             neg;
    t_chan            mag;
    logic [EST_W-1:0] est_full;
    logic [MAG_W-1:0] rem;
    t_chan            quo;
    logic [CHAN_W+1:0] val;

    assign neg = (i_to < i_from);
    assign mag = neg ? (i_from - i_to) : (i_to - i_from);

    assign est_full = EST_W'(r_prod1) * EST_W'(RECIP_MUL);

    assign rem = r_prod2 - MAG_W'(MAG_W'(r_est2) * MAG_W'(PCT_SCALE));
    assign quo = (rem >= MAG_W'(PCT_SCALE)) ? (r_est2 + CHAN_W'(1)) : r_est2;
    assign val = r_neg2 ? ({2'b00, r_from2} - {2'b00, quo})
                        : ({2'b00, r_from2} + {2'b00, quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: magnitude times progress
        r_from1 <= i_from;
        r_neg1  <= neg;
        r_prod1 <= MAG_W'(mag) * MAG_W'(i_progress);
        // stage 2: reciprocal estimate of the /1000
        r_from2 <= r_from1;
        r_neg2  <= r_neg1;
        r_prod2 <= r_prod1;
        r_est2  <= est_full[RECIP_SHIFT +: CHAN_W];
        // stage 3: correct, apply sign, clamp
        if (val[CHAN_W+1]) begin
            r_chan <= '0;
        end else if (val[CHAN_W]) begin
            r_chan <= '1;
        end else begin
            r_chan <= val[CHAN_W-1:0];
        end
    end

    assign o_valid = r_v[2];
    assign o_chan  = r_chan;

endmodule

// ===== sim/rgb_color_crossfade_tb.sv =====
// Self-checking testbench for the RGB crossfade block: directed table, then random fade sessions.
module rgb_color_crossfade_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcf_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam int unsigned HOLD_AT      = 600;   // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int          NUM_ROWS     = 25;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now;
        t_rgb        np;
        t_rgb        ns;
        logic        black;
        logic        snap;
    } t_req;

    typedef struct packed {
        t_rgb p;
        t_rgb s;
        logic changed;
        logic fading;
    } t_shown;

    // one line of the directed plan; typed rows carry a hand-written result
    typedef struct packed {
        t_row_kind kind;
        t_dur      len;
        t_req      r;
        logic      typed;
        t_shown    want;
    } t_row;

    // mirror of the block's fade state
    typedef struct {
        t_rgb        goal_p, goal_s;
        t_rgb        cur_p, cur_s;
        t_rgb        org_p, org_s;
        logic        on;
        logic [31:0] t0;
    } t_scene;

    localparam t_shown NO_WANT = '0;

    // ---------------------------------------------------------------- DUT I/O
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_cmd = 1'b0;
    logic [31:0] i_now_ms = '0;
    t_rgb        i_new_primary = '0;
    t_rgb        i_new_secondary = '0;
    logic        i_from_black = 1'b0;
    logic        i_snap_now = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_rgb        o_shown_primary;
    t_rgb        o_shown_secondary;
    logic        o_changed;
    logic        o_fading;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_dur        i_cfg_data = '0;

    rgb_color_crossfade dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_now_ms          (i_now_ms),
        .i_new_primary     (i_new_primary),
        .i_new_secondary   (i_new_secondary),
        .i_from_black      (i_from_black),
        .i_snap_now        (i_snap_now),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_shown_primary   (o_shown_primary),
        .o_shown_secondary (o_shown_secondary),
        .o_changed         (o_changed),
        .o_fading          (o_fading),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #6ns i_clk = ~i_clk;

    // ---------------------------------------------------------------- model state
    t_scene      sc;
    int unsigned fade_len = 1000;     // duration register as the block holds it
    t_shown      shown_q[$];          // expected results, oldest first
    t_row        plan[NUM_ROWS];

    int unsigned n_sent, n_ticks, n_done, n_cfg, n_seen, n_err;
    int unsigned n_cycles;
    bit          calm;                // no idling on either side
    bit          hold_done;
    int unsigned hold_left;

    // One 8-bit channel: start + trunc(delta * progress / 1000), clamped.
    function automatic t_chan mix_chan(t_chan a, t_chan b, int unsigned prog);
        int d, v;
        d = int'(b) - int'(a);
        v = int'(a) + (d * int'(prog)) / int'(PCT_SCALE);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_chan'(v);
    endfunction

    function automatic t_rgb mix_rgb(t_rgb a, t_rgb b, int unsigned prog);
        t_rgb o;
        for (int k = 0; k < 3; k++)
            o[8*k +: 8] = mix_chan(a[8*k +: 8], b[8*k +: 8], prog);
        return o;
    endfunction

    function automatic void snap_to_goal();
        sc.cur_p = sc.goal_p;
        sc.cur_s = sc.goal_s;
        sc.org_p = sc.goal_p;
        sc.org_s = sc.goal_s;
        sc.on    = 1'b0;
        sc.t0    = '0;
    endfunction

    // Advance the mirrored state by one accepted request; returns the expected result.
    function automatic t_shown crossfade_step(t_req r);
        t_shown      o;
        t_rgb        was_p, was_s;
        logic        done;
        logic [31:0] elapsed;
        longint unsigned prog;
        was_p = sc.cur_p;
        was_s = sc.cur_s;
        done  = 1'b0;
        if (r.cmd == CMD_TARGET) begin
            sc.goal_p = r.np;
            sc.goal_s = r.ns;
            if (r.snap || fade_len == 0) begin
                snap_to_goal();
            end else begin
                if (r.black) begin
                    sc.cur_p = '0;
                    sc.cur_s = '0;
                end
                if (sc.cur_p == sc.goal_p && sc.cur_s == sc.goal_s) begin
                    sc.on = 1'b0;
                    sc.t0 = '0;
                end else begin
                    sc.org_p = sc.cur_p;
                    sc.org_s = sc.cur_s;
                    sc.on    = 1'b1;
                    sc.t0    = r.now;
                end
            end
        end else if (sc.on) begin
            elapsed = r.now - sc.t0;      // wraps modulo 2^32
            if (elapsed >= fade_len) begin
                snap_to_goal();
                done = 1'b1;
            end else begin
                prog = (longint'(elapsed) * PCT_SCALE) / fade_len;
                sc.cur_p = mix_rgb(sc.org_p, sc.goal_p, int'(prog));
                sc.cur_s = mix_rgb(sc.org_s, sc.goal_s, int'(prog));
            end
        end
        if (done) n_done++;
        o.p       = sc.cur_p;
        o.s       = sc.cur_s;
        o.changed = done || sc.cur_p != was_p || sc.cur_s != was_s;
        o.fading  = sc.on;
        return o;
    endfunction

    // ---------------------------------------------------------------- request side
    // Offer one request (after random idle cycles), wait for accept, record the result.
    task automatic push_request(t_req r, logic typed, t_shown fixed);
        t_shown want;
        while (!calm && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= r.cmd;
        i_now_ms        <= r.now;
        i_new_primary   <= r.np;
        i_new_secondary <= r.ns;
        i_from_black    <= r.black;
        i_snap_now      <= r.snap;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = crossfade_step(r);
        shown_q.push_back(typed ? fixed : want);
        n_sent++;
        if (r.cmd == CMD_TICK) n_ticks++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (shown_q.size() != 0) @(posedge i_clk);
    endtask

    // Duration write, only with the block idle.
    task automatic program_duration(t_dur v);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        fade_len = 32'(v);
        n_cfg++;
    endtask

    // ---------------------------------------------------------------- result side
    // Checks each taken result and drives the receiver's stall, including the
    // single long hold-off that backs the block up into its request port.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_seen++;
                if (shown_q.size() == 0) begin
                    $error("result with nothing expected: p=%h s=%h", o_shown_primary,
                           o_shown_secondary);
                    n_err++;
                end else begin
                    t_shown e;
                    e = shown_q.pop_front();
                    if (o_shown_primary !== e.p) begin
                        $error("shown_primary: expected %h, got %h", e.p, o_shown_primary);
                        n_err++;
                    end
                    if (o_shown_secondary !== e.s) begin
                        $error("shown_secondary: expected %h, got %h", e.s, o_shown_secondary);
                        n_err++;
                    end
                    if (o_changed !== e.changed) begin
                        $error("changed: expected %b, got %b", e.changed, o_changed);
                        n_err++;
                    end
                    if (o_fading !== e.fading) begin
                        $error("fading: expected %b, got %b", e.fading, o_fading);
                        n_err++;
                    end
                end
            end
            if (!hold_done && n_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 14);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        t_req        r;
        t_dur        lens[9];
        logic [31:0] wall;
        int unsigned start, k, step;

        // reset values of the mirrored state
        sc.goal_p = 24'hFFFFFF; sc.goal_s = '0;
        sc.cur_p  = 24'hFFFFFF; sc.cur_s  = '0;
        sc.org_p  = 24'hFFFFFF; sc.org_s  = '0;
        sc.on     = 1'b0;       sc.t0     = '0;

        // Directed plan. Duration starts at its reset value of 1000.
        plan = '{
            // idle tick straight after reset
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd0, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b1, '{24'hFFFFFF, 24'h000000, 1'b0, 1'b0}},
            // snap to swapped extremes
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd5, 24'h000000, 24'hFFFFFF, 1'b0, 1'b1},
              1'b1, '{24'h000000, 24'hFFFFFF, 1'b1, 1'b0}},
            // full-swing fade starts at t=100, nothing shown changes yet
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd100, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0},
              1'b1, '{24'h000000, 24'hFFFFFF, 1'b0, 1'b1}},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd100, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b1, '{24'h000000, 24'hFFFFFF, 1'b0, 1'b1}},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd600, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            // elapsed reaches the duration exactly
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd1100, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b1, '{24'hFFFFFF, 24'h000000, 1'b1, 1'b0}},
            // already at target, no fade
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd1200, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0},
              1'b1, '{24'hFFFFFF, 24'h000000, 1'b0, 1'b0}},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd1300, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b1, '{24'hFFFFFF, 24'h000000, 1'b0, 1'b0}},
            // fade from black, last tick before the end
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd2000, 24'hFFFFFF, 24'h000000, 1'b1, 1'b0},
              1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd2999, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            // black already equals a black target
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd3000, 24'h000000, 24'h000000, 1'b1, 1'b0},
              1'b0, NO_WANT},
            // time wraps during the fade
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'hFFFFFF00, 24'h123456, 24'hABCDEF, 1'b0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'h00000100, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'h00000300, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            // zero duration snaps a target request
            '{ROW_CFG, 16'd0, '0, 1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd7, 24'hFF00FF, 24'h00FF00, 1'b0, 1'b0},
              1'b1, '{24'hFF00FF, 24'h00FF00, 1'b1, 1'b0}},
            // longest duration, then cut to zero mid-fade
            '{ROW_CFG, 16'hFFFF, '0, 1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd7, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd65541, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_CFG, 16'd0, '0, 1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd65542, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            // one-millisecond fade
            '{ROW_CFG, 16'd1, '0, 1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TARGET, 32'd42, 24'h80FF01, 24'h7F00FE, 1'b0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd42, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_REQ, 16'd0, '{CMD_TICK, 32'd43, 24'h0, 24'h0, 1'b0, 1'b0},
              1'b0, NO_WANT}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                program_duration(plan[i].len);
            else
                push_request(plan[i].r, plan[i].typed, plan[i].want);
        end

        // Random sessions, one duration each: mostly target-then-ticks sequences
        // with random colors, plus some stray requests.
        lens = '{16'd1000, 16'd0, 16'hFFFF, 16'd1, t_dur'($urandom_range(2, 20)),
                 t_dur'($urandom_range(100, 5000)), t_dur'($urandom_range(20, 300)),
                 t_dur'($urandom), 16'd1000};
        wall = $urandom;
        foreach (lens[ph]) begin
            program_duration(lens[ph]);
            calm = (ph == 2);
            if ($urandom_range(3) == 0)
                wall = 32'hFFFF_FFFF - $urandom_range(0, 3 * fade_len + 10);
            start = n_sent;
            while (n_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    // stray request, every field random
                    r.cmd   = 1'($urandom_range(1));
                    r.now   = $urandom;
                    r.np    = t_rgb'($urandom);
                    r.ns    = t_rgb'($urandom);
                    r.black = 1'($urandom_range(1));
                    r.snap  = 1'($urandom_range(1));
                    push_request(r, 1'b0, NO_WANT);
                end else begin
                    r.cmd   = CMD_TARGET;
                    r.now   = wall;
                    r.black = ($urandom_range(99) < 25);
                    r.snap  = ($urandom_range(99) < 10);
                    case ($urandom_range(7))
                        0: begin r.np = sc.cur_p; r.ns = sc.cur_s; end
                        1: begin r.np = 24'hFFFFFF; r.ns = 24'h000000; end
                        2: begin r.np = 24'h000000; r.ns = 24'hFFFFFF; end
                        3: begin
                            r.np = sc.cur_p ^ (24'h1 << $urandom_range(23));
                            r.ns = sc.cur_s;
                        end
                        default: begin r.np = t_rgb'($urandom); r.ns = t_rgb'($urandom); end
                    endcase
                    push_request(r, 1'b0, NO_WANT);
                    k = $urandom_range(1, 8);
                    while (k != 0 && sc.on) begin
                        case ($urandom_range(7))
                            0: step = 0;
                            1: step = fade_len;
                            default: step = $urandom_range(0, fade_len / 3 + 1);
                        endcase
                        wall += step;
                        r.cmd   = CMD_TICK;
                        r.now   = wall;
                        r.np    = t_rgb'($urandom);
                        r.ns    = t_rgb'($urandom);
                        r.black = 1'($urandom_range(1));
                        r.snap  = 1'($urandom_range(1));
                        push_request(r, 1'b0, NO_WANT);
                        k--;
                    end
                    wall += $urandom_range(0, 100);
                end
            end
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (%0d ticks, %0d fades run to completion)",
                 n_sent, n_ticks, n_done);
        $display("under %0d duration writes; %0d results compared, %0d mismatches.",
                 n_cfg, n_seen, n_err);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rcf_pkg.sv
rtl/rcf_div.sv
rtl/rcf_lane.sv
rtl/rgb_color_crossfade.sv
sim/rgb_color_crossfade_tb.sv
